/* rtl/core/sps_pkg.sv */
`timescale 1ns / 1ps

package sps_pkg;

   typedef enum logic [1:0] {
      MODE_SYMBOL     = 2'd0,
      MODE_NOT_SYMBOL = 2'd1,
      MODE_EXACT      = 2'd2,
      MODE_NOCASE     = 2'd3
   } mode_type;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 64;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SEARCH_MODE    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_BYTES  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LENGTH = 2'd2;

   localparam logic [3:0]  PATTERN_LENGTH_RESET = 4'd1;
   localparam logic [31:0] OUT_MAX              = 32'h0000_FFFF;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } req_word_type;

   typedef struct packed {
      logic        match_found;
      logic [15:0] match_position;
   } rsp_word_type;

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      to_upper = (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
   endfunction

endpackage

/* rtl/core/sps_req_if.sv */
`timescale 1ns / 1ps

interface sps_req_if;
   logic                 valid;
   logic                 ready;
   sps_pkg::req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/sps_rsp_if.sv */
`timescale 1ns / 1ps

interface sps_rsp_if;
   logic                 valid;
   logic                 ready;
   sps_pkg::rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/stream_pattern_search_top.sv */
`timescale 1ns / 1ps

// channel   dir  handshake     word
// req_bus   in   valid/ready   data_byte, end_of_buffer
// rsp_bus   out  valid/ready   match_found, match_position
// csr_*     in   write enable  search_mode, pattern_bytes, pattern_length
//
// One byte per cycle sustained while no waiting result stalls the input register.
// A byte is taken into the input register, whose window compare feeds the result
// register. Reset is synchronous and clears the buffer state and the valid bits of
// the registers. A waiting result only holds the input register back when the byte
// there would give another result; other bytes keep flowing.
module stream_pattern_search_top #(
   parameter int PATTERN_MAX   = 8,
   parameter int POSITION_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   sps_req_if.sink                                req_bus,
   sps_rsp_if.source                              rsp_bus,
   input  logic                                   csr_wr_en,
   input  logic [sps_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [sps_pkg::CSR_DATA_BITS-1:0]      csr_wr_data
);

   localparam int WIN_BITS = 8 * PATTERN_MAX;
   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   // configuration
   sps_pkg::mode_type mode_ff;
   logic [63:0]       pattern_ff;
   logic [3:0]        length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= sps_pkg::MODE_SYMBOL;
         pattern_ff <= '0;
         length_ff  <= sps_pkg::PATTERN_LENGTH_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            sps_pkg::CSR_SEARCH_MODE:    mode_ff    <= sps_pkg::mode_type'(csr_wr_data[1:0]);
            sps_pkg::CSR_PATTERN_BYTES:  pattern_ff <= csr_wr_data;
            sps_pkg::CSR_PATTERN_LENGTH: length_ff  <= csr_wr_data[3:0];
            default: ;
         endcase
      end
   end

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       advance;

   assign req_bus.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_byte_ff <= req_bus.data.data_byte;
         in_last_ff <= req_bus.data.end_of_buffer;
      end
   end

   // buffer state
   logic [WIN_BITS-1:0]      window_ff, window_in;
   logic [POSITION_BITS-1:0] count_ff, count_in;
   logic                     reported_ff, reported_in;

   // search
   logic [3:0]               plen;
   logic                     pattern_mode;
   logic                     nocase;
   logic [7:0]               win_b [PATTERN_MAX];
   logic [7:0]               pat_b [PATTERN_MAX];
   logic                     hit_len [PATTERN_MAX];
   logic                     pat_hit;
   logic                     hit;
   logic                     emit;
   logic [POSITION_BITS-1:0] len_so_far;
   logic [POSITION_BITS-1:0] pos;
   logic [31:0]              pos_wide;
   logic [31:0]              len_wide;
   sps_pkg::rsp_word_type    rsp_in;
   logic                     out_free;

   assign window_in    = (window_ff << 8) | WIN_BITS'(in_byte_ff);
   assign plen         = (32'(length_ff) > PATTERN_MAX) ? 4'(PATTERN_MAX) : length_ff;
   assign pattern_mode = (mode_ff == sps_pkg::MODE_EXACT) || (mode_ff == sps_pkg::MODE_NOCASE);
   assign nocase       = (mode_ff == sps_pkg::MODE_NOCASE);
   assign len_so_far   = (count_ff == POS_MAX) ? POS_MAX : count_ff + 1'b1;

   always_comb begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
         win_b[k] = window_in[8*k +: 8];
         pat_b[k] = pattern_ff[8*k +: 8];
         if (nocase) begin
            win_b[k] = sps_pkg::to_upper(win_b[k]);
            pat_b[k] = sps_pkg::to_upper(pat_b[k]);
         end
      end
      // hit_len[j]: the newest j+1 bytes equal pattern bytes 0..j, oldest first
      for (int j = 0; j < PATTERN_MAX; j++) begin
         hit_len[j] = 1'b1;
         for (int i = 0; i <= j; i++) begin
            if (win_b[j-i] != pat_b[i]) hit_len[j] = 1'b0;
         end
      end
      pat_hit = 1'b0;
      for (int j = 0; j < PATTERN_MAX; j++) begin
         if (plen == 4'(j + 1)) pat_hit = hit_len[j];
      end
   end

   always_comb begin
      hit = 1'b0;
      pos = count_ff;
      unique case (mode_ff)
         sps_pkg::MODE_SYMBOL:     hit = (in_byte_ff == pattern_ff[7:0]);
         sps_pkg::MODE_NOT_SYMBOL: hit = (in_byte_ff != pattern_ff[7:0]);
         sps_pkg::MODE_EXACT, sps_pkg::MODE_NOCASE: begin
            // no hit with a zero pattern length or too few bytes seen yet for the whole pattern
            hit = (plen != 4'd0) && (32'(count_ff) >= 32'(plen) - 32'd1) && pat_hit;
            pos = (count_ff == POS_MAX) ? POS_MAX
                                        : count_ff - POSITION_BITS'(plen - 4'd1);
         end
      endcase
   end

   assign pos_wide = 32'(pos);
   assign len_wide = 32'(len_so_far);
   assign emit     = !reported_ff && (hit || in_last_ff);

   always_comb begin
      rsp_in.match_found = hit;
      if (hit) begin
         rsp_in.match_position = (pos_wide > sps_pkg::OUT_MAX) ? 16'hFFFF : pos_wide[15:0];
      end else if (pattern_mode && length_ff == 4'd0) begin
         rsp_in.match_position = 16'd0;
      end else begin
         rsp_in.match_position = (len_wide > sps_pkg::OUT_MAX) ? 16'hFFFF : len_wide[15:0];
      end
   end

   assign out_free = !rsp_bus.valid || rsp_bus.ready;
   assign advance  = in_valid_ff && (!emit || out_free);

   always_comb begin
      count_in    = count_ff;
      reported_in = reported_ff;
      if (in_last_ff) begin
         count_in    = '0;
         reported_in = 1'b0;
      end else begin
         count_in = len_so_far;
         if (!reported_ff && hit) reported_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= '0;
         count_ff    <= '0;
         reported_ff <= 1'b0;
      end else if (advance) begin
         count_ff    <= count_in;
         reported_ff <= reported_in;
         if (in_last_ff) begin
            window_ff <= '0;
         end else if (!reported_ff) begin
            window_ff <= window_in;
         end
      end
   end

   // result register
   logic                  rsp_valid_ff;
   sps_pkg::rsp_word_type rsp_word_ff;

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_word_ff <= rsp_in;
      end
   end

endmodule
